[rtl/itda_pkg.sv]
package itda_pkg;

  // tile geometry
  localparam int unsigned TileRows     = 4;
  localparam int unsigned ColumnGroups = 8;
  localparam int unsigned ColsPerGroup = 4;
  localparam int unsigned TileSlots    = TileRows * ColumnGroups;
  localparam int unsigned SlotIdxW     = (TileSlots > 1) ? $clog2(TileSlots) : 1;

  localparam int unsigned AccW  = 32;
  localparam int unsigned ByteW = 8;

  // saturation bounds of a pair sum
  localparam logic signed [17:0] PairMax = 18'sd32767;
  localparam logic signed [17:0] PairMin = -18'sd32768;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAC  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [1:0]         row;
    logic [2:0]         group;
    logic [31:0]        a_quad;
    logic [31:0]        b_col0;
    logic [31:0]        b_col1;
    logic [31:0]        b_col2;
    logic [31:0]        b_col3;
    logic signed [31:0] init0;
    logic signed [31:0] init1;
    logic signed [31:0] init2;
    logic signed [31:0] init3;
  } in_t;

  typedef struct packed {
    logic signed [31:0] acc0;
    logic signed [31:0] acc1;
    logic signed [31:0] acc2;
    logic signed [31:0] acc3;
  } out_t;

  // four accumulators of one row and group, element c is column c
  typedef logic [ColsPerGroup-1:0][AccW-1:0] acc_slot_t;

  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] idx;
    acc_slot_t           data;
  } tile_wr_t;

endpackage

[rtl/itda_quad_dot.sv]
module itda_quad_dot import itda_pkg::*; (
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  output logic signed [31:0]  dot_o
);

  logic signed [16:0] prod [4];
  logic signed [17:0] pair_lo;
  logic signed [17:0] pair_hi;
  logic signed [15:0] sat_lo;
  logic signed [15:0] sat_hi;
  logic signed [16:0] sum;

  // unsigned activation byte times signed weight byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = 17'($signed({1'b0, a_i[ByteW*i +: ByteW]}))
              * 17'($signed(b_i[ByteW*i +: ByteW]));
    end
  end

  assign pair_lo = 18'(prod[0]) + 18'(prod[1]);
  assign pair_hi = 18'(prod[2]) + 18'(prod[3]);

  always_comb begin
    if (pair_lo > PairMax) begin
      sat_lo = 16'sh7fff;
    end else if (pair_lo < PairMin) begin
      sat_lo = -16'sh8000;
    end else begin
      sat_lo = pair_lo[15:0];
    end
    if (pair_hi > PairMax) begin
      sat_hi = 16'sh7fff;
    end else if (pair_hi < PairMin) begin
      sat_hi = -16'sh8000;
    end else begin
      sat_hi = pair_hi[15:0];
    end
  end

  assign sum   = 17'(sat_lo) + 17'(sat_hi);
  assign dot_o = 32'(sum);

endmodule

[rtl/itda_acc_tile.sv]
module itda_acc_tile import itda_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SlotIdxW-1:0] rd_idx_i,
  output acc_slot_t           rd_data_o,
  input  tile_wr_t            wr_i
);

  acc_slot_t             mem_q [TileSlots];
  logic [TileSlots-1:0]  valid_q;

  // a slot never written since reset reads as zero
  assign rd_data_o = valid_q[rd_idx_i] ? mem_q[rd_idx_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

endmodule

[rtl/int8_tile_dot_accumulate.sv]
// channel | dir | handshake               | payload
// --------+-----+-------------------------+---------------------------------
// in      | in  | in_valid_i / in_ready_o | in_i  : op, row, group, operands
// out     | out | out_valid_o/out_ready_i | out_o : acc0..acc3
//
// one beat in, one beat out; a beat passes through the input register and then
// the result register before it leaves on the out channel
// sustained rate is one beat per cycle without stalls; the tile is read,
// updated and written back as the beat leaves the input register, so consecutive
// beats to the same row and group see each other's updates without forwarding
// reset clears the pipeline valids and all tile slots (per-slot valid bits)
// a stall on out_ready_i holds the result register and the input register,
// and backs up into in_ready_o in the same cycle
module int8_tile_dot_accumulate import itda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  // input register
  in_t  in_q;
  logic s1_valid_q;

  // result register
  out_t out_q;
  logic out_valid_q;

  logic out_free;
  logic s1_fire;

  logic                in_range;
  logic [SlotIdxW-1:0] slot_idx;
  acc_slot_t           slot_rd;
  acc_slot_t           slot_new;
  tile_wr_t            tile_wr;
  logic [31:0]         b_col [ColsPerGroup];
  logic signed [31:0]  init_v [ColsPerGroup];
  logic signed [31:0]  dot [ColsPerGroup];
  out_t                out_d;

  // result register takes a beat when empty or draining this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // slot address of the row and group
  assign in_range = (32'(in_q.row) < TileRows) && (32'(in_q.group) < ColumnGroups);
  assign slot_idx = SlotIdxW'(32'(in_q.row) * ColumnGroups + 32'(in_q.group));

  itda_acc_tile u_tile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (slot_idx),
    .rd_data_o (slot_rd),
    .wr_i      (tile_wr)
  );

  assign b_col[0]  = in_q.b_col0;
  assign b_col[1]  = in_q.b_col1;
  assign b_col[2]  = in_q.b_col2;
  assign b_col[3]  = in_q.b_col3;
  assign init_v[0] = in_q.init0;
  assign init_v[1] = in_q.init1;
  assign init_v[2] = in_q.init2;
  assign init_v[3] = in_q.init3;

  // one dot unit per column of the group
  for (genvar c = 0; c < ColsPerGroup; c++) begin : g_col
    itda_quad_dot u_dot (
      .a_i   (in_q.a_quad),
      .b_i   (b_col[c]),
      .dot_o (dot[c])
    );
  end

  // load replaces, mac adds with 32-bit wrap
  always_comb begin
    for (int c = 0; c < ColsPerGroup; c++) begin
      unique case (in_q.op)
        OP_LOAD: slot_new[c] = init_v[c];
        OP_MAC:  slot_new[c] = slot_rd[c] + dot[c];
        default: slot_new[c] = slot_rd[c];
      endcase
    end
  end

  // out-of-range address leaves the tile alone and returns zeros
  assign tile_wr.en   = s1_fire && in_range;
  assign tile_wr.idx  = slot_idx;
  assign tile_wr.data = slot_new;

  always_comb begin
    if (in_range) begin
      out_d.acc0 = slot_new[0];
      out_d.acc1 = slot_new[1];
      out_d.acc2 = slot_new[2];
      out_d.acc3 = slot_new[3];
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[bench/tile_acc_checker.sv]
module tile_acc_checker import itda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int PairCeil  = 32767;
  localparam int PairFloor = -32768;

  // shadow of the accumulator tile
  logic signed [AccW-1:0] tile_model [TileRows][ColumnGroups][ColsPerGroup];
  out_t                   expected_accs [$];
  out_t                   want;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, exp_val);
    fail_count_o++;
  endtask

  function automatic int sat_pair(int v);
    if (v > PairCeil) return PairCeil;
    if (v < PairFloor) return PairFloor;
    return v;
  endfunction

  // u8 x s8 quad dot product, pair sums saturated to 16 bits
  function automatic logic signed [31:0] dot4_u8s8(logic [31:0] a, logic [31:0] b);
    int prod [4];
    for (int i = 0; i < 4; i++) begin
      prod[i] = int'(a[8*i +: 8]) * int'($signed(b[8*i +: 8]));
    end
    return sat_pair(prod[0] + prod[1]) + sat_pair(prod[2] + prod[3]);
  endfunction

  // applies one beat to the shadow tile and returns the updated accumulators
  function automatic out_t tile_step(in_t item);
    logic signed [AccW-1:0] acc [ColsPerGroup];
    logic [31:0]            wcol [ColsPerGroup];
    logic signed [31:0]     icol [ColsPerGroup];
    out_t                   res;
    wcol = '{item.b_col0, item.b_col1, item.b_col2, item.b_col3};
    icol = '{item.init0, item.init1, item.init2, item.init3};
    res  = '0;
    if (int'(item.row) < int'(TileRows) && int'(item.group) < int'(ColumnGroups)) begin
      for (int c = 0; c < ColsPerGroup; c++) begin
        if (item.op == OP_LOAD) begin
          tile_model[item.row][item.group][c] = icol[c];
        end else begin
          tile_model[item.row][item.group][c] =
            tile_model[item.row][item.group][c] + dot4_u8s8(item.a_quad, wcol[c]);
        end
        acc[c] = tile_model[item.row][item.group][c];
      end
      res.acc0 = acc[0];
      res.acc1 = acc[1];
      res.acc2 = acc[2];
      res.acc3 = acc[3];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tile_model[r, g, c]) tile_model[r][g][c] = '0;
      expected_accs.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_accs.size() == 0) begin
          report_mismatch("result beat with nothing pending, acc0", out_i.acc0, '0);
        end else begin
          want = expected_accs.pop_front();
          if (out_i.acc0 !== want.acc0) report_mismatch("acc0", out_i.acc0, want.acc0);
          if (out_i.acc1 !== want.acc1) report_mismatch("acc1", out_i.acc1, want.acc1);
          if (out_i.acc2 !== want.acc2) report_mismatch("acc2", out_i.acc2, want.acc2);
          if (out_i.acc3 !== want.acc3) report_mismatch("acc3", out_i.acc3, want.acc3);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_accs.push_back(tile_step(in_i));
      end
      pending_o <= expected_accs.size();
    end
  end

endmodule

[bench/int8_tile_dot_accumulate_test.sv]
module int8_tile_dot_accumulate_test;
  import itda_pkg::*;

  // stimulus sizing
  localparam int RandItems  = 1700;
  localparam int CalmAfter  = 1500;  // no idling from here on
  localparam int DrainWait  = 8;     // cycles after the last result
  localparam int PhaseLen   = 64;    // cycles between idling-rate changes

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_i        = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_o;

  int   fail_count;
  int   pending;

  // idling control
  int   sent       = 0;
  bit   calm       = 1'b0;
  int   stall_left = 0;
  int   stall_pct  = 20;
  int   gap_pct    = 20;
  int   phase_ctr  = 0;

  logic [1:0] seq_row;
  logic [2:0] seq_grp;
  int         run_len;

  always #4 clk_i = ~clk_i;

  int8_tile_dot_accumulate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  tile_acc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_i         (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i        (out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // weight / activation word, bytes biased toward the saturating corners
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0:       w[8*i +: 8] = 8'h00;
        1:       w[8*i +: 8] = 8'hFF;
        2:       w[8*i +: 8] = 8'h80;
        3:       w[8*i +: 8] = 8'h7F;
        default: w[8*i +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  // accumulator load value, often close to the wrap points
  function automatic logic signed [31:0] rand_init();
    case ($urandom_range(0, 5))
      0:       return 32'sh0000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return 32'sh7FFF_FFFF - $urandom_range(0, 70000);
      4:       return 32'sh8000_0000 + $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  // load beat; operand fields carry junk since the block ignores them
  function automatic in_t make_load(logic [1:0] row, logic [2:0] grp,
                                    logic [31:0] i0, logic [31:0] i1,
                                    logic [31:0] i2, logic [31:0] i3);
    in_t item;
    item.op     = OP_LOAD;
    item.row    = row;
    item.group  = grp;
    item.a_quad = $urandom;
    item.b_col0 = $urandom;
    item.b_col1 = $urandom;
    item.b_col2 = $urandom;
    item.b_col3 = $urandom;
    item.init0  = i0;
    item.init1  = i1;
    item.init2  = i2;
    item.init3  = i3;
    return item;
  endfunction

  // multiply-accumulate beat; init fields carry junk
  function automatic in_t make_mac(logic [1:0] row, logic [2:0] grp, logic [31:0] a,
                                   logic [31:0] b0, logic [31:0] b1,
                                   logic [31:0] b2, logic [31:0] b3);
    in_t item;
    item.op     = OP_MAC;
    item.row    = row;
    item.group  = grp;
    item.a_quad = a;
    item.b_col0 = b0;
    item.b_col1 = b1;
    item.b_col2 = b2;
    item.b_col3 = b3;
    item.init0  = $urandom;
    item.init1  = $urandom;
    item.init2  = $urandom;
    item.init3  = $urandom;
    return item;
  endfunction

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_beat(in_t item);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (sent == CalmAfter) calm <= 1'b1;
  endtask

  // result side: random stall bursts, rate changes by phase
  always @(posedge clk_i) begin
    phase_ctr <= (phase_ctr == PhaseLen - 1) ? 0 : phase_ctr + 1;
    if (phase_ctr == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 10;
        2:       stall_pct <= 30;
        default: stall_pct <= 50;
      endcase
      case ($urandom_range(0, 3))
        0:       gap_pct <= 0;
        1:       gap_pct <= 10;
        2:       gap_pct <= 30;
        default: gap_pct <= 50;
      endcase
    end
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fresh block, then saturation both ways, zero activations, mixed bytes
    send_beat(make_load(2'd0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_beat(make_mac(2'd0, 3'd0, 32'hFFFF_FFFF, 32'h8080_8080, 32'h7F7F_7F7F,
                       32'h0000_0000, 32'h7F80_807F));
    send_beat(make_mac(2'd0, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080,
                       32'h7F7F_7F7F, 32'h0101_0101));
    send_beat(make_mac(2'd0, 3'd0, 32'h0101_0101, 32'hFFFF_FFFF, 32'h0101_0101,
                       32'h80FF_7F01, 32'hFF80_01FF));

    // accumulators at the extremes, wrap up and down on the next steps
    send_beat(make_load(2'd3, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                        32'hFFFF_FFFF));
    send_beat(make_mac(2'd3, 3'd7, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h8080_8080,
                       32'h7F7F_7F7F, 32'h8080_8080));
    // only the upper pair saturates
    send_beat(make_mac(2'd3, 3'd7, 32'hFFFF_0000, 32'h8080_7F7F, 32'h7F7F_8080,
                       32'h8080_8080, 32'h7F7F_7F7F));

    // slot never loaded, still at its reset value
    send_beat(make_mac(2'd2, 3'd5, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h8080_8080,
                       32'h0102_0304, 32'hFEFD_FCFB));

    // pair sum just below the limit, no saturation
    send_beat(make_load(2'd1, 3'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000));
    send_beat(make_mac(2'd1, 3'd3, 32'h00FF_00FF, 32'h7F80_7F80, 32'h807F_807F,
                       32'h0000_7F7F, 32'h8080_0000));

    // every row once, load then accumulate
    for (int r = 0; r < 4; r++) begin
      send_beat(make_load(2'(r), 3'(r + 4), rand_init(), rand_init(), rand_init(),
                          rand_init()));
      send_beat(make_mac(2'(r), 3'(r + 4), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word()));
    end

    // random part: mostly load-then-accumulate runs on one slot, with stray
    // beats to other slots and runs that skip the load
    sent = 0;
    while (sent < RandItems) begin
      seq_row = 2'($urandom_range(0, 3));
      seq_grp = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_beat(make_load(seq_row, seq_grp, 32'h0, 32'h0, 32'h0, 32'h0));
        end else begin
          send_beat(make_load(seq_row, seq_grp, rand_init(), rand_init(), rand_init(),
                              rand_init()));
        end
      end
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        if ($urandom_range(0, 5) == 0) begin
          send_beat(make_mac(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             rand_word(), rand_word(), rand_word(), rand_word(),
                             rand_word()));
        end else begin
          send_beat(make_mac(seq_row, seq_grp, rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word()));
        end
      end
    end
    in_valid_i <= 1'b0;

    // drain, then watch for stray result beats
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/itda_pkg.sv
rtl/itda_quad_dot.sv
rtl/itda_acc_tile.sv
rtl/int8_tile_dot_accumulate.sv
bench/tile_acc_checker.sv
bench/int8_tile_dot_accumulate_test.sv
